### hdl/c8dec_pkg.sv
// ----------------------------------------------------------------------------
// c8dec_pkg
// Shared types and constants for the chip-8 / schip instruction decoder:
// instruction class codes, opcode group and sub-code values, decode record.
// ----------------------------------------------------------------------------
`default_nettype none

package c8dec_pkg;

   // field widths
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned CLASS_W = 6;

   // address of the first instruction and per-instruction stride
   localparam logic [ADDR_W-1:0] START_ADDR = 16'h0200;
   localparam logic [ADDR_W-1:0] INSTR_STEP = 16'h0002;
   localparam logic [ADDR_W-1:0] SKIP_STEP  = 16'h0004;
   localparam logic [15:0]       LIMIT_RST  = 16'h0FFF;

   // instruction classes
   localparam logic [CLASS_W-1:0] CLS_CLS     = 6'd0;
   localparam logic [CLASS_W-1:0] CLS_RTS     = 6'd1;
   localparam logic [CLASS_W-1:0] CLS_SCRIGHT = 6'd2;
   localparam logic [CLASS_W-1:0] CLS_SCLEFT  = 6'd3;
   localparam logic [CLASS_W-1:0] CLS_LOW     = 6'd4;
   localparam logic [CLASS_W-1:0] CLS_HIGH    = 6'd5;
   localparam logic [CLASS_W-1:0] CLS_SCDOWN  = 6'd6;
   localparam logic [CLASS_W-1:0] CLS_JMP     = 6'd7;
   localparam logic [CLASS_W-1:0] CLS_JSR     = 6'd8;
   localparam logic [CLASS_W-1:0] CLS_SKEQ_I  = 6'd9;
   localparam logic [CLASS_W-1:0] CLS_SKNE_I  = 6'd10;
   localparam logic [CLASS_W-1:0] CLS_SKEQ_R  = 6'd11;
   localparam logic [CLASS_W-1:0] CLS_MOV_I   = 6'd12;
   localparam logic [CLASS_W-1:0] CLS_ADD_I   = 6'd13;
   localparam logic [CLASS_W-1:0] CLS_MOV_R   = 6'd14;
   localparam logic [CLASS_W-1:0] CLS_OR      = 6'd15;
   localparam logic [CLASS_W-1:0] CLS_AND     = 6'd16;
   localparam logic [CLASS_W-1:0] CLS_XOR     = 6'd17;
   localparam logic [CLASS_W-1:0] CLS_ADD_R   = 6'd18;
   localparam logic [CLASS_W-1:0] CLS_SUB     = 6'd19;
   localparam logic [CLASS_W-1:0] CLS_SHR     = 6'd20;
   localparam logic [CLASS_W-1:0] CLS_RSB     = 6'd21;
   localparam logic [CLASS_W-1:0] CLS_SHL     = 6'd22;
   localparam logic [CLASS_W-1:0] CLS_SKNE_R  = 6'd23;
   localparam logic [CLASS_W-1:0] CLS_MVI     = 6'd24;
   localparam logic [CLASS_W-1:0] CLS_JMI     = 6'd25;
   localparam logic [CLASS_W-1:0] CLS_RAND    = 6'd26;
   localparam logic [CLASS_W-1:0] CLS_XSPRITE = 6'd27;
   localparam logic [CLASS_W-1:0] CLS_SPRITE  = 6'd28;
   localparam logic [CLASS_W-1:0] CLS_SKPR    = 6'd29;
   localparam logic [CLASS_W-1:0] CLS_SKUP    = 6'd30;
   localparam logic [CLASS_W-1:0] CLS_GDELAY  = 6'd31;
   localparam logic [CLASS_W-1:0] CLS_KEY     = 6'd32;
   localparam logic [CLASS_W-1:0] CLS_SDELAY  = 6'd33;
   localparam logic [CLASS_W-1:0] CLS_SSOUND  = 6'd34;
   localparam logic [CLASS_W-1:0] CLS_ADI     = 6'd35;
   localparam logic [CLASS_W-1:0] CLS_FONT    = 6'd36;
   localparam logic [CLASS_W-1:0] CLS_XFONT   = 6'd37;
   localparam logic [CLASS_W-1:0] CLS_BCD     = 6'd38;
   localparam logic [CLASS_W-1:0] CLS_STR     = 6'd39;
   localparam logic [CLASS_W-1:0] CLS_LDR     = 6'd40;
   localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 6'd41;

   // opcode groups (top nibble)
   localparam logic [3:0] GRP_SYS  = 4'h0;
   localparam logic [3:0] GRP_JMP  = 4'h1;
   localparam logic [3:0] GRP_JSR  = 4'h2;
   localparam logic [3:0] GRP_SKEI = 4'h3;
   localparam logic [3:0] GRP_SKNI = 4'h4;
   localparam logic [3:0] GRP_SKER = 4'h5;
   localparam logic [3:0] GRP_MOVI = 4'h6;
   localparam logic [3:0] GRP_ADDI = 4'h7;
   localparam logic [3:0] GRP_ALU  = 4'h8;
   localparam logic [3:0] GRP_SKNR = 4'h9;
   localparam logic [3:0] GRP_MVI  = 4'hA;
   localparam logic [3:0] GRP_JMI  = 4'hB;
   localparam logic [3:0] GRP_RAND = 4'hC;
   localparam logic [3:0] GRP_SPR  = 4'hD;
   localparam logic [3:0] GRP_KEY  = 4'hE;
   localparam logic [3:0] GRP_MISC = 4'hF;

   // group zero low bytes
   localparam logic [7:0] SYS_CLS     = 8'hE0;
   localparam logic [7:0] SYS_RTS     = 8'hEE;
   localparam logic [7:0] SYS_SCRIGHT = 8'hFB;
   localparam logic [7:0] SYS_SCLEFT  = 8'hFC;
   localparam logic [7:0] SYS_LOW     = 8'hFE;
   localparam logic [7:0] SYS_HIGH    = 8'hFF;

   // alu group sub-codes
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_RSB = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // key skip low bytes
   localparam logic [7:0] KEY_SKPR = 8'h9E;
   localparam logic [7:0] KEY_SKUP = 8'hA1;

   // misc group low bytes
   localparam logic [7:0] MSC_GDELAY = 8'h07;
   localparam logic [7:0] MSC_KEY    = 8'h0A;
   localparam logic [7:0] MSC_SDELAY = 8'h15;
   localparam logic [7:0] MSC_SSOUND = 8'h18;
   localparam logic [7:0] MSC_ADI    = 8'h1E;
   localparam logic [7:0] MSC_FONT   = 8'h29;
   localparam logic [7:0] MSC_XFONT  = 8'h30;
   localparam logic [7:0] MSC_BCD    = 8'h33;
   localparam logic [7:0] MSC_STR    = 8'h55;
   localparam logic [7:0] MSC_LDR    = 8'h65;

   // one decoded instruction
   typedef struct packed {
      logic [ADDR_W-1:0]  instr_address;
      logic [CLASS_W-1:0] instr_class;
      logic [3:0]         reg_x;
      logic [3:0]         reg_y;
      logic [3:0]         nibble_n;
      logic [7:0]         byte_nn;
      logic [11:0]        addr_nnn;
      logic               is_jump;
      logic               is_call;
      logic [ADDR_W-1:0]  branch_target;
      logic               record_branch;
   } result_type;

endpackage

`default_nettype wire

### hdl/c8dec_decode.sv
// ----------------------------------------------------------------------------
// c8dec_decode
// Combinational decode of one instruction word and its address into class,
// operand fields, flow flags, branch target and record flag.
// ----------------------------------------------------------------------------
`default_nettype none

module c8dec_decode (
   input  wire logic [15:0]             word,
   input  wire logic [15:0]             address,
   input  wire logic [15:0]             target_limit,
   output c8dec_pkg::result_type        result
);

   logic [3:0]  grp;
   logic [7:0]  lo;
   logic [3:0]  n;
   logic [11:0] nnn;
   logic [5:0]  cls;
   logic        jump;
   logic        call;
   logic [15:0] target;
   logic [15:0] skip_target;

   assign grp         = word[15:12];
   assign lo          = word[7:0];
   assign n           = word[3:0];
   assign nnn         = word[11:0];
   assign skip_target = 16'(address + c8dec_pkg::SKIP_STEP);

   // class and flow decode by top nibble
   always_comb begin
      cls    = c8dec_pkg::CLS_UNKNOWN;
      jump   = 1'b0;
      call   = 1'b0;
      target = '0;
      unique case (grp)
         c8dec_pkg::GRP_SYS: begin
            unique case (lo)
               c8dec_pkg::SYS_CLS:     cls = c8dec_pkg::CLS_CLS;
               c8dec_pkg::SYS_RTS:     cls = c8dec_pkg::CLS_RTS;
               c8dec_pkg::SYS_SCRIGHT: cls = c8dec_pkg::CLS_SCRIGHT;
               c8dec_pkg::SYS_SCLEFT:  cls = c8dec_pkg::CLS_SCLEFT;
               c8dec_pkg::SYS_LOW:     cls = c8dec_pkg::CLS_LOW;
               c8dec_pkg::SYS_HIGH:    cls = c8dec_pkg::CLS_HIGH;
               default:                cls = c8dec_pkg::CLS_SCDOWN;
            endcase
         end
         c8dec_pkg::GRP_JMP: begin
            cls    = c8dec_pkg::CLS_JMP;
            jump   = 1'b1;
            target = {4'h0, nnn};
         end
         c8dec_pkg::GRP_JSR: begin
            cls    = c8dec_pkg::CLS_JSR;
            call   = 1'b1;
            target = {4'h0, nnn};
         end
         c8dec_pkg::GRP_SKEI: begin
            cls    = c8dec_pkg::CLS_SKEQ_I;
            jump   = 1'b1;
            target = skip_target;
         end
         c8dec_pkg::GRP_SKNI: begin
            cls    = c8dec_pkg::CLS_SKNE_I;
            jump   = 1'b1;
            target = skip_target;
         end
         c8dec_pkg::GRP_SKER: begin
            cls    = c8dec_pkg::CLS_SKEQ_R;
            jump   = 1'b1;
            target = skip_target;
         end
         c8dec_pkg::GRP_MOVI: cls = c8dec_pkg::CLS_MOV_I;
         c8dec_pkg::GRP_ADDI: cls = c8dec_pkg::CLS_ADD_I;
         c8dec_pkg::GRP_ALU: begin
            unique case (n)
               c8dec_pkg::ALU_MOV: cls = c8dec_pkg::CLS_MOV_R;
               c8dec_pkg::ALU_OR:  cls = c8dec_pkg::CLS_OR;
               c8dec_pkg::ALU_AND: cls = c8dec_pkg::CLS_AND;
               c8dec_pkg::ALU_XOR: cls = c8dec_pkg::CLS_XOR;
               c8dec_pkg::ALU_ADD: cls = c8dec_pkg::CLS_ADD_R;
               c8dec_pkg::ALU_SUB: cls = c8dec_pkg::CLS_SUB;
               c8dec_pkg::ALU_SHR: cls = c8dec_pkg::CLS_SHR;
               c8dec_pkg::ALU_RSB: cls = c8dec_pkg::CLS_RSB;
               c8dec_pkg::ALU_SHL: cls = c8dec_pkg::CLS_SHL;
               default:            cls = c8dec_pkg::CLS_UNKNOWN;
            endcase
         end
         c8dec_pkg::GRP_SKNR: cls = c8dec_pkg::CLS_SKNE_R;
         c8dec_pkg::GRP_MVI:  cls = c8dec_pkg::CLS_MVI;
         c8dec_pkg::GRP_JMI: begin
            cls    = c8dec_pkg::CLS_JMI;
            jump   = 1'b1;
            target = {4'h0, nnn};
         end
         c8dec_pkg::GRP_RAND: cls = c8dec_pkg::CLS_RAND;
         c8dec_pkg::GRP_SPR: begin
            cls = (n == 4'h0) ? c8dec_pkg::CLS_XSPRITE : c8dec_pkg::CLS_SPRITE;
         end
         c8dec_pkg::GRP_KEY: begin
            unique case (lo)
               c8dec_pkg::KEY_SKPR: cls = c8dec_pkg::CLS_SKPR;
               c8dec_pkg::KEY_SKUP: cls = c8dec_pkg::CLS_SKUP;
               default:             cls = c8dec_pkg::CLS_UNKNOWN;
            endcase
         end
         c8dec_pkg::GRP_MISC: begin
            unique case (lo)
               c8dec_pkg::MSC_GDELAY: cls = c8dec_pkg::CLS_GDELAY;
               c8dec_pkg::MSC_KEY:    cls = c8dec_pkg::CLS_KEY;
               c8dec_pkg::MSC_SDELAY: cls = c8dec_pkg::CLS_SDELAY;
               c8dec_pkg::MSC_SSOUND: cls = c8dec_pkg::CLS_SSOUND;
               c8dec_pkg::MSC_ADI:    cls = c8dec_pkg::CLS_ADI;
               c8dec_pkg::MSC_FONT:   cls = c8dec_pkg::CLS_FONT;
               c8dec_pkg::MSC_XFONT:  cls = c8dec_pkg::CLS_XFONT;
               c8dec_pkg::MSC_BCD:    cls = c8dec_pkg::CLS_BCD;
               c8dec_pkg::MSC_STR:    cls = c8dec_pkg::CLS_STR;
               c8dec_pkg::MSC_LDR:    cls = c8dec_pkg::CLS_LDR;
               default:               cls = c8dec_pkg::CLS_UNKNOWN;
            endcase
         end
         default: cls = c8dec_pkg::CLS_UNKNOWN;
      endcase
   end

   // pack the result, record flag checks the target window
   always_comb begin
      result.instr_address = address;
      result.instr_class   = cls;
      result.reg_x         = word[11:8];
      result.reg_y         = word[7:4];
      result.nibble_n      = n;
      result.byte_nn       = lo;
      result.addr_nnn      = nnn;
      result.is_jump       = jump;
      result.is_call       = call;
      result.branch_target = target;
      result.record_branch = (jump || call) && (target >= c8dec_pkg::START_ADDR)
                             && (target <= target_limit);
   end

endmodule

`default_nettype wire

### hdl/chip8_instruction_decoder.sv
// ----------------------------------------------------------------------------
// chip8_instruction_decoder
// Decodes a stream of chip-8 / schip instruction words, tagging each with
// its address and giving class, operands, flow flags and branch target.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_opcode_word
//  rsp      out        rsp_valid/rsp_ready  rsp_instr_address .. rsp_record_branch
//  csr      in         csr_wr_en            csr_wr_data (target_limit)
//
//  one beat per clock in and out while rsp_ready holds; each beat goes
//  through the input register, then decode into the result register:
//  two register stages. reset clears both stage valids, sets the
//  address to 0x200 and the limit to 0xFFF. a stalled result holds while
//  the input stage keeps one more beat; req_ready drops only when both
//  stages are full and stalled.
//
`default_nettype none

module chip8_instruction_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_opcode_word,
   // response
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_instr_address,
   output logic [5:0]       rsp_instr_class,
   output logic [3:0]       rsp_reg_x,
   output logic [3:0]       rsp_reg_y,
   output logic [3:0]       rsp_nibble_n,
   output logic [7:0]       rsp_byte_nn,
   output logic [11:0]      rsp_addr_nnn,
   output logic             rsp_is_jump,
   output logic             rsp_is_call,
   output logic [15:0]      rsp_branch_target,
   output logic             rsp_record_branch,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic                  limit_ff;
   logic [15:0]           target_limit_ff;
   logic [15:0]           addr_ff;
   logic [15:0]           addr_in;
   logic                  in_valid_ff;
   logic [15:0]           in_word_ff;
   logic [15:0]           in_addr_ff;
   logic                  out_valid_ff;
   c8dec_pkg::result_type out_ff;
   c8dec_pkg::result_type decoded;
   logic                  req_beat;
   logic                  out_load;
   logic                  in_advance;

   // handshake: result register frees when empty or taken
   assign out_load   = !out_valid_ff || rsp_ready;
   assign in_advance = in_valid_ff && out_load;
   assign req_ready  = !in_valid_ff || out_load;
   assign req_beat   = req_valid && req_ready;
   assign addr_in    = 16'(addr_ff + c8dec_pkg::INSTR_STEP);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_limit_ff <= c8dec_pkg::LIMIT_RST;
         limit_ff        <= 1'b0;
      end else if (csr_wr_en) begin
         target_limit_ff <= csr_wr_data;
         limit_ff        <= 1'b1;
      end
   end

   // instruction address counter
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= c8dec_pkg::START_ADDR;
      end else if (req_beat) begin
         addr_ff <= addr_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_word_ff <= req_opcode_word;
         in_addr_ff <= addr_ff;
      end
   end

   // decode
   c8dec_decode u_decode (
      .word         (in_word_ff),
      .address      (in_addr_ff),
      .target_limit (target_limit_ff),
      .result       (decoded)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         out_ff <= decoded;
      end
   end

   // outputs
   assign rsp_valid         = out_valid_ff;
   assign rsp_instr_address = out_ff.instr_address;
   assign rsp_instr_class   = out_ff.instr_class;
   assign rsp_reg_x         = out_ff.reg_x;
   assign rsp_reg_y         = out_ff.reg_y;
   assign rsp_nibble_n      = out_ff.nibble_n;
   assign rsp_byte_nn       = out_ff.byte_nn;
   assign rsp_addr_nnn      = out_ff.addr_nnn;
   assign rsp_is_jump       = out_ff.is_jump;
   assign rsp_is_call       = out_ff.is_call;
   assign rsp_branch_target = out_ff.branch_target;
   assign rsp_record_branch = out_ff.record_branch;

   // checks
   a_addr_step: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (addr_ff == 16'($past(addr_ff) + c8dec_pkg::INSTR_STEP)))
      else $error("address did not advance by one instruction");

   a_addr_hold: assert property (@(posedge clock) disable iff (reset)
      !req_beat |=> $stable(addr_ff))
      else $error("address moved without an input beat");

   a_flow_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.is_jump && out_ff.is_call))
      else $error("result flagged as both jump and call");

   a_record_flow: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.record_branch) |-> (out_ff.is_jump || out_ff.is_call))
      else $error("branch recorded without a flow flag");

   a_call_class: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_call) |-> (out_ff.instr_class == c8dec_pkg::CLS_JSR))
      else $error("call flag on a class other than jsr");

   a_limit_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && !limit_ff) |=> limit_ff)
      else $error("limit write not tracked");

endmodule

`default_nettype wire
